@@ sv/swmc_pkg.sv @@
// Package for the sliding-window mean and centred sum of squares block.
// Holds payload structs, controller state enum and controller/datapath command types.
// No dependencies.
`timescale 1ns / 1ps
package swmc_pkg;
	localparam int SAMPLE_BITS = 16;
	localparam int WLEN_BITS  = 11;
	localparam int CSS_BITS   = 41;
	localparam logic [WLEN_BITS-1:0] WLEN_RESET = 11'd64;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          start_series;
	} in_beat_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] window_mean;
		logic [CSS_BITS-1:0]           centered_sum_sq;
	} out_beat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_DIV_START,
		ST_DIV_RUN,
		ST_SQ,
		ST_CEIL,
		ST_DIV2_RUN,
		ST_FINISH,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load_item;
		logic read_old;
		logic update;
		logic div_start;
		logic sq_step;
		logic ceil_step;
		logic div2_start;
		logic finish;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic full;
		logic div_done;
	} ctrl_sts_t;
endpackage

@@ sv/swmc_ctrl.sv @@
// Controller state machine for the sliding-window statistics block.
// Depends on swmc_pkg.
`timescale 1ns / 1ps
module swmc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  swmc_pkg::ctrl_sts_t  sts,
	output swmc_pkg::ctrl_cmd_t  cmd
);
	swmc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swmc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			swmc_pkg::ST_IDLE:      if (in_valid) state_d = swmc_pkg::ST_READ;
			swmc_pkg::ST_READ:      state_d = swmc_pkg::ST_UPDATE;
			swmc_pkg::ST_UPDATE:    state_d = swmc_pkg::ST_DIV_START;
			swmc_pkg::ST_DIV_START: state_d = sts.full ? swmc_pkg::ST_DIV_RUN
			                                           : swmc_pkg::ST_IDLE;
			swmc_pkg::ST_DIV_RUN:   if (sts.div_done) state_d = swmc_pkg::ST_SQ;
			swmc_pkg::ST_SQ:        state_d = swmc_pkg::ST_CEIL;
			swmc_pkg::ST_CEIL:      state_d = swmc_pkg::ST_DIV2_RUN;
			swmc_pkg::ST_DIV2_RUN:  if (sts.div_done) state_d = swmc_pkg::ST_FINISH;
			swmc_pkg::ST_FINISH:    state_d = swmc_pkg::ST_OUT;
			swmc_pkg::ST_OUT:       if (out_ready) state_d = swmc_pkg::ST_IDLE;
			default:                state_d = swmc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			swmc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load_item = in_valid;
			end
			swmc_pkg::ST_READ:      cmd.read_old = 1'b1;
			swmc_pkg::ST_UPDATE:    cmd.update = 1'b1;
			swmc_pkg::ST_DIV_START: cmd.div_start = sts.full;
			swmc_pkg::ST_DIV_RUN:   ;
			swmc_pkg::ST_SQ:        cmd.sq_step = 1'b1;
			swmc_pkg::ST_CEIL: begin
				cmd.ceil_step = 1'b1;
				cmd.div2_start = 1'b1;
			end
			swmc_pkg::ST_DIV2_RUN:  ;
			swmc_pkg::ST_FINISH:    cmd.finish = 1'b1;
			swmc_pkg::ST_OUT: begin
				out_valid = 1'b1;
				cmd.emit = out_ready;
			end
			default: ;
		endcase
	end
endmodule

@@ sv/swmc_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
// No package dependencies.
`timescale 1ns / 1ps
module swmc_div #(
	parameter int NUM_BITS = 32,
	parameter int DEN_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] num,
	input  logic [DEN_BITS-1:0] den,
	output logic                done,
	output logic [NUM_BITS-1:0] quo,
	output logic [DEN_BITS-1:0] rem
);
	localparam int CNT_BITS = $clog2(NUM_BITS + 1);
	logic [NUM_BITS-1:0] quo_q;
	logic [DEN_BITS-1:0] rem_q, den_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic [DEN_BITS:0]   trial;

	assign trial = {rem_q, quo_q[NUM_BITS-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_BITS'(NUM_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_BITS'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= DEN_BITS'(trial - {1'b0, den_q});
				quo_q <= {quo_q[NUM_BITS-2:0], 1'b1};
			end else begin
				rem_q <= trial[DEN_BITS-1:0];
				quo_q <= {quo_q[NUM_BITS-2:0], 1'b0};
			end
		end
	end

	assign done = busy_q && (cnt_q == CNT_BITS'(1));
	assign quo = quo_q;
	assign rem = rem_q;
endmodule

@@ sv/swmc_dp.sv @@
// Datapath: sample ring memory, running sums, shared divider and result arithmetic.
// Depends on swmc_pkg and swmc_div.
`timescale 1ns / 1ps
module swmc_dp #(
	parameter int MAX_WINDOW  = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [swmc_pkg::WLEN_BITS-1:0]     window_len,
	input  logic                               cfg_we,
	input  logic signed [SAMPLE_BITS-1:0]      sample,
	input  logic                               start_series,
	input  swmc_pkg::ctrl_cmd_t                cmd,
	output swmc_pkg::ctrl_sts_t                sts,
	output logic signed [SAMPLE_BITS-1:0]      window_mean,
	output logic [swmc_pkg::CSS_BITS-1:0]      centered_sum_sq
);
	localparam int PTR_BITS = $clog2(MAX_WINDOW);
	localparam int LEN_BITS = $clog2(MAX_WINDOW + 1);
	localparam int SQ_BITS  = 2 * SAMPLE_BITS;
	localparam int SUM_BITS = SAMPLE_BITS + LEN_BITS;
	localparam int SSQ_BITS = swmc_pkg::CSS_BITS;
	localparam int QL_BITS  = 2 * SUM_BITS;

	logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] x_q, old_q;
	logic [PTR_BITS-1:0] wp_q;
	logic [LEN_BITS-1:0] fill_q, len_q;
	logic signed [SUM_BITS-1:0] sum_q;
	logic [SSQ_BITS-1:0] ssq_q;
	logic drop_q, full_q, neg_q;
	logic [PTR_BITS-1:0] old_idx;
	logic [LEN_BITS-1:0] len_c;
	logic [SQ_BITS-1:0] xsq, osq;
	logic [QL_BITS-1:0] qq_q;
	logic [QL_BITS-1:0] ceil_q;
	logic [SSQ_BITS-1:0] q1_q;
	logic [LEN_BITS-1:0] r1_q;
	logic [SUM_BITS-1:0] qm_q;

	logic div_start;
	logic [QL_BITS-1:0] div_num;
	logic div_done;
	logic [QL_BITS-1:0] div_quo;
	logic [LEN_BITS-1:0] div_rem;

	always_comb begin
		if (window_len < 11'd2) len_c = LEN_BITS'(2);
		else if ({{(32-swmc_pkg::WLEN_BITS){1'b0}}, window_len} > 32'(MAX_WINDOW))
			len_c = LEN_BITS'(MAX_WINDOW);
		else len_c = LEN_BITS'(window_len);
	end

	// Old sample sits len positions behind the write pointer (mod MAX_WINDOW).
	assign old_idx = PTR_BITS'(({1'b0, wp_q} + (PTR_BITS+1)'(MAX_WINDOW) -
	                           (PTR_BITS+1)'(len_q)) % (PTR_BITS+1)'(MAX_WINDOW));
	assign xsq = SQ_BITS'(x_q * x_q);
	assign osq = SQ_BITS'(old_q * old_q);

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			x_q <= sample;
			len_q <= len_c;
		end
		if (cmd.read_old) old_q <= ring[old_idx];
		if (cmd.update) ring[wp_q] <= x_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			fill_q <= '0;
			sum_q <= '0;
			ssq_q <= '0;
			drop_q <= 1'b0;
			full_q <= 1'b0;
		end else if (cfg_we) begin
			fill_q <= '0;
			sum_q <= '0;
			ssq_q <= '0;
		end else begin
			if (cmd.load_item && start_series) begin
				fill_q <= '0;
				sum_q <= '0;
				ssq_q <= '0;
			end
			if (cmd.read_old) drop_q <= (fill_q >= len_q);
			if (cmd.update) begin
				if (drop_q) begin
					sum_q <= sum_q - SUM_BITS'(old_q) + SUM_BITS'(x_q);
					ssq_q <= ssq_q - SSQ_BITS'(osq) + SSQ_BITS'(xsq);
				end else begin
					sum_q <= sum_q + SUM_BITS'(x_q);
					ssq_q <= ssq_q + SSQ_BITS'(xsq);
					fill_q <= fill_q + 1'b1;
				end
				full_q <= drop_q || (fill_q + 1'b1 >= len_q);
				wp_q <= (wp_q == PTR_BITS'(MAX_WINDOW - 1)) ? '0 : wp_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			neg_q <= sum_q[SUM_BITS-1];
		end
		if (cmd.sq_step) begin
			qm_q <= SUM_BITS'(div_quo);
			r1_q <= div_rem;
			qq_q <= QL_BITS'(div_quo[SUM_BITS-1:0] * div_quo[SUM_BITS-1:0]);
		end
		if (cmd.ceil_step) begin
			// q*q*L + 2*q*r, with r*r + L - 1 handed to the divider.
			ceil_q <= QL_BITS'(qq_q * len_q) +
			          QL_BITS'({QL_BITS'(qm_q * r1_q), 1'b0});
		end
		if (cmd.finish) begin
			q1_q <= SSQ_BITS'(ceil_q + div_quo);
		end
	end

	assign div_start = cmd.div_start || cmd.div2_start;
	assign div_num = cmd.div2_start
		? QL_BITS'(r1_q * r1_q + len_q - 1'b1)
		: QL_BITS'(sum_q[SUM_BITS-1] ? SUM_BITS'(-sum_q) : SUM_BITS'(sum_q));

	swmc_div #(.NUM_BITS(QL_BITS), .DEN_BITS(LEN_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(len_q), .done(div_done), .quo(div_quo), .rem(div_rem)
	);

	logic [SUM_BITS-1:0] mean_mag;
	assign mean_mag = qm_q;
	assign window_mean = neg_q ? SAMPLE_BITS'(-mean_mag) : SAMPLE_BITS'(mean_mag);
	assign centered_sum_sq = (ssq_q >= q1_q) ? ssq_q - q1_q : '0;
	assign sts.full = full_q;
	assign sts.div_done = div_done;
endmodule

@@ sv/sliding_window_mean_and_css.sv @@
// Sliding-window mean and centred sum of squares: top level.
// Joins the controller (swmc_ctrl) and datapath (swmc_dp); uses swmc_pkg.
//
// Usage: each input beat on in_valid/in_ready carries one signed sample and a
// start_series flag that restarts the series before the sample is taken. The
// block keeps the last L samples in an on-chip ring with a running sum and a
// running sum of squares, where L is window_len clamped to [2, MAX_WINDOW].
// Once the window is full, every sample produces one output beat with the
// window mean (truncated towards zero) and the centred sum of squares.
// Until then a sample produces no output beat.
// Sequence: a sample that yields no result passes through the read, update and
// divider-start states before the next sample is accepted. One with a result
// then runs the mean division, the square and ceiling steps, the second
// division and a finish step before its output beat is offered; the
// bit-serial divider is shared by both quotients.
// One item is in flight at a time; while an output beat waits for out_ready
// the block holds it and accepts no further sample.
// Writing window_len (cfg_we) restarts the series. Reset clears the sums,
// fill count and write pointer, sets window_len to 64; the ring is not
// cleared since an entry's value is only used after being written in a series.
`timescale 1ns / 1ps
module sliding_window_mean_and_css #(
	parameter int MAX_WINDOW  = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  swmc_pkg::in_beat_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output swmc_pkg::out_beat_t                 out_data,
	input  logic                                cfg_we,
	input  logic [swmc_pkg::WLEN_BITS-1:0]      cfg_data
);
	swmc_pkg::ctrl_cmd_t cmd;
	swmc_pkg::ctrl_sts_t sts;
	logic [swmc_pkg::WLEN_BITS-1:0] window_len_q;

	// Window length register; a write restarts the series in the datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= swmc_pkg::WLEN_RESET;
		end else if (cfg_we) begin
			window_len_q <= cfg_data;
		end
	end

	swmc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
	);

	swmc_dp #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(swmc_pkg::SAMPLE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .window_len(window_len_q), .cfg_we(cfg_we),
		.sample(in_data.sample), .start_series(in_data.start_series),
		.cmd(cmd), .sts(sts), .window_mean(out_data.window_mean),
		.centered_sum_sq(out_data.centered_sum_sq)
	);
endmodule

@@ sv/swmc_checker.sv @@
// Port-level checker for the sliding-window statistics block, with its bind.
// Depends on swmc_pkg and sliding_window_mean_and_css.
`timescale 1ns / 1ps
module swmc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input swmc_pkg::out_beat_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat dropped or changed while stalled");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is pending");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("back-to-back acceptance");
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("result appeared too early");
endmodule

bind sliding_window_mean_and_css swmc_checker u_swmc_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

@@ tb/sliding_window_mean_and_css_test.sv @@
// Self-checking testbench for the sliding-window mean and centred sum of squares block.
// A clocked driver and monitor check every output beat against an in-file predictor.
// Depends on swmc_pkg and sliding_window_mean_and_css.
`timescale 1ns / 1ps
module sliding_window_mean_and_css_test;
	localparam int MAX_WIN  = 1024;
	localparam int WDOG_MAX = 20000;
	localparam int DRAIN    = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	swmc_pkg::in_beat_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	swmc_pkg::out_beat_t out_data;
	logic cfg_we = 1'b0;
	logic [swmc_pkg::WLEN_BITS-1:0] cfg_data = '0;

	always #1 clk = ~clk;

	sliding_window_mean_and_css u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	// Predictor state: a private copy of the ring, pointers and sums.
	logic signed [15:0] win_ring [MAX_WIN];
	int unsigned wr_ptr;
	int unsigned filled;
	longint signed run_sum;
	longint unsigned run_sq;
	logic [swmc_pkg::WLEN_BITS-1:0] win_len_reg;

	swmc_pkg::in_beat_t  pending_samples[$];
	swmc_pkg::out_beat_t expected_stats[$];
	int fail_count = 0;
	int beats_in = 0;
	int beats_out = 0;
	int wdog = 0;
	bit stim_done = 1'b0;
	bit in_taken = 1'b0;

	function automatic void restart_predictor();
		filled = 0;
		run_sum = 0;
		run_sq = 0;
	endfunction

	// Advances the predictor by one sample and queues a result once the window is full.
	function automatic void predict_window(swmc_pkg::in_beat_t b);
		int unsigned len;
		int unsigned old_idx;
		longint signed x;
		longint signed o;
		longint unsigned mag, q, r, ceil_sq, css;
		swmc_pkg::out_beat_t res;
		len = win_len_reg;
		if (len < 2) len = 2;
		if (len > MAX_WIN) len = MAX_WIN;
		x = b.sample;
		if (b.start_series) restart_predictor();
		if (filled >= len) begin
			old_idx = (wr_ptr >= len) ? wr_ptr - len : wr_ptr + MAX_WIN - len;
			o = win_ring[old_idx];
			run_sum -= o;
			run_sq -= longint'(o * o);
		end else begin
			filled++;
		end
		run_sum += x;
		run_sq += longint'(x * x);
		win_ring[wr_ptr] = b.sample;
		wr_ptr = (wr_ptr + 1 >= MAX_WIN) ? 0 : wr_ptr + 1;
		if (filled < len) return;
		mag = (run_sum < 0) ? -run_sum : run_sum;
		q = mag / len;
		r = mag % len;
		ceil_sq = q * q * len + 2 * q * r + (r * r + len - 1) / len;
		css = (run_sq >= ceil_sq) ? run_sq - ceil_sq : 0;
		res.window_mean = 16'(run_sum / longint'(len));
		res.centered_sum_sq = css[swmc_pkg::CSS_BITS-1:0];
		expected_stats.push_back(res);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch on %s at beat %0d: got %0h, expected %0h", what, beats_out, got, want);
		fail_count++;
	endtask

	// Input acceptance is seen at the rising edge and fed to the predictor there.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			predict_window(in_data);
			beats_in++;
			in_taken = 1'b1;
		end
	end

	// Driver: waits a random gap before each beat, holds it until accepted.
	int in_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				in_taken = 1'b0;
				in_valid <= 1'b0;
				in_gap = $urandom_range(0, 15);
				if ($urandom_range(0, 3) == 0) in_gap = 0;
			end else if (!in_valid) begin
				if (in_gap > 0) in_gap--;
				else if (pending_samples.size() > 0) begin
					in_data <= pending_samples.pop_front();
					in_valid <= 1'b1;
				end
			end
		end
	end

	// Receiver back-pressure: the stall for each result is drawn afresh.
	int out_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				out_gap = $urandom_range(0, 15);
				if ($urandom_range(0, 3) == 0) out_gap = 0;
				out_ready <= (out_gap == 0);
			end else if (out_gap > 0) begin
				out_gap--;
				out_ready <= (out_gap == 0);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Monitor: checks every accepted result beat against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			beats_out++;
			if (expected_stats.size() == 0) begin
				report_mismatch("unexpected beat", out_data, 0);
			end else begin
				swmc_pkg::out_beat_t want;
				want = expected_stats.pop_front();
				if (out_data.window_mean !== want.window_mean)
					report_mismatch("window_mean", out_data.window_mean, want.window_mean);
				if (out_data.centered_sum_sq !== want.centered_sum_sq)
					report_mismatch("centered_sum_sq", out_data.centered_sum_sq,
						want.centered_sum_sq);
			end
		end
	end

	// Watchdog on cycles without any accepted beat.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || stim_done)
			wdog <= 0;
		else if (arst_n)
			wdog <= wdog + 1;
		if (wdog >= WDOG_MAX) begin
			$display("watchdog expired with %0d results outstanding", expected_stats.size());
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'($urandom_range(0, 15)) - 16'sd8;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_sample(input logic signed [15:0] s, input logic st);
		swmc_pkg::in_beat_t b;
		b.sample = s;
		b.start_series = st;
		pending_samples.push_back(b);
	endtask

	// Waits until the block is quiet, then writes a new window length.
	task automatic set_window(input logic [swmc_pkg::WLEN_BITS-1:0] len);
		wait (pending_samples.size() == 0 && !in_valid);
		wait (expected_stats.size() == 0);
		repeat (DRAIN) @(negedge clk);
		cfg_data <= len;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		win_len_reg = len;
		restart_predictor();
	endtask

	initial begin
		int k;
		int run_len;
		logic [swmc_pkg::WLEN_BITS-1:0] lens [6];
		win_len_reg = swmc_pkg::WLEN_RESET;
		wr_ptr = 0;
		restart_predictor();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: full-scale samples at the reset length of 64, then lengths 0, 1 and 3, restarts included.
		for (k = 0; k < 3; k++) push_sample(16'sh7fff, 1'b0);
		set_window(11'd0);
		push_sample(16'sh7fff, 1'b0);
		push_sample(16'sh8000, 1'b0);
		push_sample(16'sh8000, 1'b0);
		push_sample(16'sh7fff, 1'b0);
		push_sample(-16'sd3, 1'b1);
		push_sample(16'sd2, 1'b0);
		push_sample(-16'sd1, 1'b0);
		set_window(11'd1);
		push_sample(16'sh0001, 1'b0);
		push_sample(16'sh0000, 1'b0);
		set_window(11'd3);
		for (k = 0; k < 6; k++) push_sample(16'sh8000, 1'b0);
		push_sample(16'sh7fff, 1'b1);
		push_sample(16'shffff, 1'b0);
		push_sample(16'sh5555, 1'b0);
		push_sample(16'shaaaa, 1'b0);

		// Random phases over several lengths; the longest ones only check that
		// no result appears before the window fills.
		lens = '{11'd2, 11'd5, 11'd17, 11'd64, 11'd1024, 11'd2047};
		foreach (lens[i]) begin
			set_window(lens[i]);
			run_len = (lens[i] >= 1024) ? 80 : 100;
			for (k = 0; k < run_len; k++)
				push_sample(rand_sample(), ($urandom_range(0, 60) == 0));
		end
		set_window(11'($urandom_range(2, 40)));
		for (k = 0; k < 80; k++) push_sample(rand_sample(), ($urandom_range(0, 30) == 0));

		wait (pending_samples.size() == 0 && !in_valid);
		wait (expected_stats.size() == 0);
		stim_done = 1'b1;
		repeat (DRAIN) @(negedge clk);
		$display("sent %0d samples and checked %0d window results", beats_in, beats_out);
		$display("window lengths covered from below 2 to above the ring size");
		if (fail_count == 0 && expected_stats.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
